>>> src/range_fusion_avoidance_core_defines.svh
// Assertion macros used by the range fusion avoidance core.
`ifndef RANGE_FUSION_AVOIDANCE_CORE_DEFINES_SVH
`define RANGE_FUSION_AVOIDANCE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rfa same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define RFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rfa next-cycle check failed");

`endif

>>> src/rfa_pkg.sv
// Types and constants of the range fusion avoidance block.
package rfa_pkg;

    localparam int FUSED_W = 17;   // fused tenths never exceed 81900

    localparam logic [FUSED_W-1:0] NO_RANGE_TENTHS   = 17'd81900;
    localparam logic [15:0]        LASER_VALID_LIMIT = 16'd8000;
    localparam logic [11:0]        SONAR_LOW_LIMIT   = 12'd20;
    localparam logic [11:0]        SONAR_HIGH_LIMIT  = 12'd4000;
    localparam logic [3:0]         FULL_WEIGHT       = 4'd10;

    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_CENTER = 2'd1;
    localparam logic [1:0] SIDE_RIGHT  = 2'd2;

    localparam logic [2:0] HD_FWD        = 3'd0;
    localparam logic [2:0] HD_FWD_LEFT   = 3'd1;
    localparam logic [2:0] HD_FWD_RIGHT  = 3'd2;
    localparam logic [2:0] HD_TURN_LEFT  = 3'd3;
    localparam logic [2:0] HD_TURN_RIGHT = 3'd4;
    localparam logic [2:0] HD_BACK       = 3'd5;
    localparam logic [2:0] HD_STOP       = 3'd6;

    localparam logic [6:0] SPD_CRUISE = 7'd80;
    localparam logic [6:0] SPD_VEER   = 7'd60;
    localparam logic [6:0] SPD_SQUEEZE = 7'd50;
    localparam logic [6:0] SPD_TURN   = 7'd40;
    localparam logic [6:0] SPD_SLOW   = 7'd30;
    localparam logic [6:0] SPD_HALT   = 7'd0;

    typedef struct packed {
        logic [2:0] heading;
        logic [6:0] speed;
        logic       right_blk;
        logic       center_blk;
        logic       left_blk;
    } t_decision;

endpackage

>>> src/range_fusion_avoidance_core.sv
// Range fusion obstacle avoidance: one transaction in per cycle while the output side
// keeps up, passing the fusion register, then the store update and decision into the output
// register; a stalled output holds the fusion stage and input ready falls only once both
// registers are full.
module range_fusion_avoidance_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // laser_mm[15:0], sonar_mm[27:16]
    input  logic [1:0]  s_axis_tuser,   // position[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // heading[2:0], speed[9:3], left_blk[10],
                                        // center_blk[11], right_blk[12],
                                        // fused_tenths[32:13]
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_wdata
);

    localparam logic [1:0] CFG_OBSTACLE = 2'd0;
    localparam logic [1:0] CFG_RETREAT  = 2'd1;
    localparam logic [1:0] CFG_HALT     = 2'd2;
    localparam logic [1:0] CFG_WEIGHT   = 2'd3;
    localparam int         FW           = rfa_pkg::FUSED_W;

    logic [FW-1:0] r_obs_tenths, r_ret_tenths, r_hlt_tenths;
    logic [3:0]    r_weight;
    logic [FW-1:0] cfg_tenths;

    logic [FW-1:0] r_store [3];
    logic [FW-1:0] n_left, n_center, n_right;

    logic          r_s1_vld;
    logic [1:0]    r_s1_pos;
    logic [FW-1:0] r_s1_fused;
    logic [FW-1:0] fused;

    logic               r_out_vld;
    rfa_pkg::t_decision r_out_dec;
    logic [FW-1:0]      r_out_fused;
    rfa_pkg::t_decision decision;

    logic out_en;
    logic s1_adv;
    logic in_acc;
    logic s1_left_wr;

    assign out_en = !r_out_vld || m_axis_tready;
    assign s1_adv = r_s1_vld && out_en;
    assign s_axis_tready = !r_s1_vld || out_en;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s1_left_wr = s1_adv && (r_s1_pos == rfa_pkg::SIDE_LEFT);

    // thresholds kept in tenths so the compares need no scaling
    assign cfg_tenths = FW'(i_cfg_wdata) * FW'(10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_tenths <= FW'(3000);
            r_ret_tenths <= FW'(1500);
            r_hlt_tenths <= FW'(800);
            r_weight     <= 4'd7;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_OBSTACLE: r_obs_tenths <= cfg_tenths;
                CFG_RETREAT:  r_ret_tenths <= cfg_tenths;
                CFG_HALT:     r_hlt_tenths <= cfg_tenths;
                CFG_WEIGHT:   r_weight     <= i_cfg_wdata[3:0];
                default:      r_weight     <= r_weight;
            endcase
        end
    end

    rfa_fuse u_fuse (
        .i_laser_mm (s_axis_tdata[15:0]),
        .i_sonar_mm (s_axis_tdata[27:16]),
        .i_weight   (r_weight),
        .o_fused    (fused)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pos   <= s_axis_tuser;
            r_s1_fused <= fused;
        end
    end

    // decide on the store as it stands after this transaction's write
    assign n_left   = (r_s1_pos == rfa_pkg::SIDE_LEFT)   ? r_s1_fused : r_store[0];
    assign n_center = (r_s1_pos == rfa_pkg::SIDE_CENTER) ? r_s1_fused : r_store[1];
    assign n_right  = (r_s1_pos == rfa_pkg::SIDE_RIGHT)  ? r_s1_fused : r_store[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store[0] <= rfa_pkg::NO_RANGE_TENTHS;
            r_store[1] <= rfa_pkg::NO_RANGE_TENTHS;
            r_store[2] <= rfa_pkg::NO_RANGE_TENTHS;
        end else if (s1_adv) begin
            r_store[0] <= n_left;
            r_store[1] <= n_center;
            r_store[2] <= n_right;
        end
    end

    rfa_decide u_decide (
        .i_left            (n_left),
        .i_center          (n_center),
        .i_right           (n_right),
        .i_obstacle_tenths (r_obs_tenths),
        .i_retreat_tenths  (r_ret_tenths),
        .i_halt_tenths     (r_hlt_tenths),
        .o_decision        (decision)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_dec   <= decision;
            r_out_fused <= r_s1_fused;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, 20'(r_out_fused), r_out_dec.right_blk,
                            r_out_dec.center_blk, r_out_dec.left_blk,
                            r_out_dec.speed, r_out_dec.heading};

`include "range_fusion_avoidance_core_defines.svh"

    `RFA_ASSERT_SAME(a_s1_holds_on_stall, r_s1_vld && !out_en, !s_axis_tready)
    `RFA_ASSERT_NEXT(a_accept_fills_s1, in_acc, r_s1_vld)
    `RFA_ASSERT_NEXT(a_advance_fills_out, s1_adv, r_out_vld)
    `RFA_ASSERT_NEXT(a_left_store_write, s1_left_wr, r_store[0] == $past(r_s1_fused))

endmodule

>>> src/rfa_fuse.sv
// Laser and ultrasonic range fusion into tenths of a millimeter.
module rfa_fuse (
    input  logic [15:0]                  i_laser_mm,
    input  logic [11:0]                  i_sonar_mm,
    input  logic [3:0]                   i_weight,
    output logic [rfa_pkg::FUSED_W-1:0]  o_fused
);

    logic        laser_ok;
    logic        sonar_ok;
    logic [3:0]  w_laser;
    logic [3:0]  w_sonar;
    logic [19:0] laser_part;
    logic [15:0] sonar_part;
    logic [19:0] mix_sum;
    logic [19:0] laser_x10;
    logic [15:0] sonar_x10;

    assign laser_ok = i_laser_mm < rfa_pkg::LASER_VALID_LIMIT;
    assign sonar_ok = (i_sonar_mm > rfa_pkg::SONAR_LOW_LIMIT) &&
                      (i_sonar_mm < rfa_pkg::SONAR_HIGH_LIMIT);

    // clamp the laser weight to a full ten tenths
    assign w_laser = (i_weight > rfa_pkg::FULL_WEIGHT) ? rfa_pkg::FULL_WEIGHT : i_weight;
    assign w_sonar = rfa_pkg::FULL_WEIGHT - w_laser;

    assign laser_part = 20'(w_laser) * 20'(i_laser_mm);
    assign sonar_part = 16'(w_sonar) * 16'(i_sonar_mm);
    assign mix_sum    = laser_part + 20'(sonar_part);
    assign laser_x10  = 20'(i_laser_mm) * 20'd10;
    assign sonar_x10  = 16'(i_sonar_mm) * 16'd10;

    always_comb begin
        priority if (laser_ok && sonar_ok) begin
            o_fused = mix_sum[rfa_pkg::FUSED_W-1:0];
        end else if (laser_ok) begin
            o_fused = laser_x10[rfa_pkg::FUSED_W-1:0];
        end else if (sonar_ok) begin
            o_fused = rfa_pkg::FUSED_W'(sonar_x10);
        end else begin
            o_fused = rfa_pkg::NO_RANGE_TENTHS;
        end
    end

endmodule

>>> src/rfa_decide.sv
// Blocked flags, heading and speed from the three stored distances.
module rfa_decide (
    input  logic [rfa_pkg::FUSED_W-1:0] i_left,
    input  logic [rfa_pkg::FUSED_W-1:0] i_center,
    input  logic [rfa_pkg::FUSED_W-1:0] i_right,
    input  logic [rfa_pkg::FUSED_W-1:0] i_obstacle_tenths,
    input  logic [rfa_pkg::FUSED_W-1:0] i_retreat_tenths,
    input  logic [rfa_pkg::FUSED_W-1:0] i_halt_tenths,
    output rfa_pkg::t_decision          o_decision
);

    logic lb, cb, rb;
    logic all_retreat;
    logic all_halt;

    assign lb = i_left   < i_obstacle_tenths;
    assign cb = i_center < i_obstacle_tenths;
    assign rb = i_right  < i_obstacle_tenths;

    assign all_retreat = (i_left < i_retreat_tenths) && (i_center < i_retreat_tenths) &&
                         (i_right < i_retreat_tenths);
    assign all_halt    = (i_left < i_halt_tenths) && (i_center < i_halt_tenths) &&
                         (i_right < i_halt_tenths);

    always_comb begin
        o_decision.left_blk   = lb;
        o_decision.center_blk = cb;
        o_decision.right_blk  = rb;
        // halt beats retreat, retreat beats the steering table
        priority if (all_halt) begin
            o_decision.heading = rfa_pkg::HD_STOP;
            o_decision.speed   = rfa_pkg::SPD_HALT;
        end else if (all_retreat) begin
            o_decision.heading = rfa_pkg::HD_BACK;
            o_decision.speed   = rfa_pkg::SPD_SLOW;
        end else if (!lb && !cb && !rb) begin
            o_decision.heading = rfa_pkg::HD_FWD;
            o_decision.speed   = rfa_pkg::SPD_CRUISE;
        end else if (!cb && lb && !rb) begin
            o_decision.heading = rfa_pkg::HD_FWD_RIGHT;
            o_decision.speed   = rfa_pkg::SPD_VEER;
        end else if (!cb && !lb && rb) begin
            o_decision.heading = rfa_pkg::HD_FWD_LEFT;
            o_decision.speed   = rfa_pkg::SPD_VEER;
        end else if (!cb) begin
            o_decision.heading = rfa_pkg::HD_FWD;
            o_decision.speed   = rfa_pkg::SPD_SQUEEZE;
        end else if (!lb && rb) begin
            o_decision.heading = rfa_pkg::HD_TURN_LEFT;
            o_decision.speed   = rfa_pkg::SPD_TURN;
        end else if (lb && !rb) begin
            o_decision.heading = rfa_pkg::HD_TURN_RIGHT;
            o_decision.speed   = rfa_pkg::SPD_TURN;
        end else if (!lb || (i_left > i_right)) begin
            o_decision.heading = rfa_pkg::HD_TURN_LEFT;
            o_decision.speed   = rfa_pkg::SPD_SLOW;
        end else begin
            o_decision.heading = rfa_pkg::HD_TURN_RIGHT;
            o_decision.speed   = rfa_pkg::SPD_SLOW;
        end
    end

endmodule
